[hdl/mwd_pkg.sv]
// shared constants and controller command type for the multiword divider
package mwd_pkg;

   // operand geometry
   localparam int WORDS   = 32;
   localparam int WORD_W  = 32;
   localparam int TOTAL_W = WORDS * WORD_W;

   // counter widths
   localparam int STEP_W  = (TOTAL_W > 1) ? $clog2(TOTAL_W) : 1;
   localparam int LOAD_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // shift a new request word pair into the operands
      logic init;       // clear the partial remainder
      logic step;       // one restoring shift-subtract step
      logic shift_out;  // drop the quotient word just presented
   } dp_cmd_type;

endpackage

[hdl/mwd_datapath.sv]
// operand, remainder and quotient registers with the restoring step logic
module mwd_datapath (
   input  logic                          clock,
   input  mwd_pkg::dp_cmd_type           cmd,
   input  logic [mwd_pkg::WORD_W-1:0]    req_dividend_word,
   input  logic [mwd_pkg::WORD_W-1:0]    req_divisor_word,
   output logic [mwd_pkg::WORD_W-1:0]    rsp_quotient_word
);

   // dividend that turns into the quotient as bits shift through it
   logic [mwd_pkg::TOTAL_W-1:0] dq_ff, dq_in;
   logic [mwd_pkg::TOTAL_W-1:0] divisor_ff, divisor_in;
   logic [mwd_pkg::TOTAL_W-1:0] rem_ff, rem_in;

   logic [mwd_pkg::TOTAL_W:0]   shifted;
   logic [mwd_pkg::TOTAL_W:0]   diff;
   logic                        take;

   // shift remainder left bringing in the top dividend bit, then trial subtract
   assign shifted = {rem_ff, dq_ff[mwd_pkg::TOTAL_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign take    = ~diff[mwd_pkg::TOTAL_W];

   // next-state selection
   always_comb begin
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (cmd.load) begin
         dq_in      = {req_dividend_word, dq_ff[mwd_pkg::TOTAL_W-1:mwd_pkg::WORD_W]};
         divisor_in = {req_divisor_word, divisor_ff[mwd_pkg::TOTAL_W-1:mwd_pkg::WORD_W]};
      end
      if (cmd.init) begin
         rem_in = '0;
      end
      if (cmd.step) begin
         rem_in = take ? diff[mwd_pkg::TOTAL_W-1:0] : shifted[mwd_pkg::TOTAL_W-1:0];
         dq_in  = {dq_ff[mwd_pkg::TOTAL_W-2:0], take};
      end
      if (cmd.shift_out) begin
         dq_in = {{mwd_pkg::WORD_W{1'b0}}, dq_ff[mwd_pkg::TOTAL_W-1:mwd_pkg::WORD_W]};
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign rsp_quotient_word = dq_ff[mwd_pkg::WORD_W-1:0];

endmodule

[hdl/mwd_ctrl.sv]
// sequencer for loading, the bit loop and quotient word output
module mwd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output logic                 rsp_last_word,
   output mwd_pkg::dp_cmd_type  cmd
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [mwd_pkg::LOAD_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [mwd_pkg::STEP_W-1:0]  step_cnt_ff, step_cnt_in;

   logic accept;
   logic last_load;
   logic last_step;
   logic last_out;

   assign accept    = start && (state_ff == ST_LOAD);
   assign last_load = load_cnt_ff == mwd_pkg::LOAD_W'(mwd_pkg::WORDS - 1);
   assign last_step = step_cnt_ff == mwd_pkg::STEP_W'(mwd_pkg::TOTAL_W - 1);
   assign last_out  = step_cnt_ff == mwd_pkg::STEP_W'(mwd_pkg::WORDS - 1);

   // next state, counters and datapath commands
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (last_load) begin
                  cmd.init    = 1'b1;
                  load_cnt_in = '0;
                  step_cnt_in = '0;
                  state_in    = ST_DIV;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (last_step) begin
               step_cnt_in = '0;
               state_in    = ST_OUT;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            cmd.shift_out = 1'b1;
            if (last_out) begin
               step_cnt_in = '0;
               state_in    = ST_LOAD;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   // handshake and result strobes
   assign busy          = state_ff != ST_LOAD;
   assign rsp_valid     = state_ff == ST_OUT;
   assign rsp_last_word = (state_ff == ST_OUT) && last_out;

endmodule

[hdl/multiword_restoring_divider.sv]
// top level of the unsigned multiword restoring divider
//
// Usage: each request carries one 32-bit dividend word and the divisor word
// at the same position, least significant first; a request is taken at a
// clock edge where start is high and busy is low. Requests that are not the
// WORDS-th of a run only store their words and produce nothing.
// The WORDS-th request starts the divide: busy rises for the shift-subtract
// loop (one quotient bit per cycle, set by the full-width trial subtractor),
// then stays high while rsp_valid strobes the WORDS quotient words, one per
// cycle, least significant first, rsp_last_word marking the most significant.
// A zero divisor yields an all-ones quotient.
// Reset (synchronous, active high) empties the load count and stops any
// divide in progress. Results cannot be held off: each word is on the rsp_
// ports for exactly one cycle.
module multiword_restoring_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [mwd_pkg::WORD_W-1:0]  req_dividend_word,
   input  logic [mwd_pkg::WORD_W-1:0]  req_divisor_word,
   output logic                        rsp_valid,
   output logic [mwd_pkg::WORD_W-1:0]  rsp_quotient_word,
   output logic                        rsp_last_word
);

   mwd_pkg::dp_cmd_type cmd;

   // controller
   mwd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_last_word (rsp_last_word),
      .cmd           (cmd)
   );

   // datapath
   mwd_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_dividend_word (req_dividend_word),
      .req_divisor_word  (req_divisor_word),
      .rsp_quotient_word (rsp_quotient_word)
   );

endmodule

[hdl/mwd_checker.sv]
// port-level checks for the multiword divider, bound to the top level
module mwd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_word
);

   // results only come out while the block is busy
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // the last-word flag only rides on a result
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_word |-> rsp_valid)
      else $error("last word flag without result strobe");

   // after the last word the block takes requests again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last_word |=> !busy)
      else $error("still busy after last word");

   // busy ends only with the last quotient word
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_last_word))
      else $error("busy dropped without last word");

endmodule

bind multiword_restoring_divider mwd_checker u_mwd_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_last_word (rsp_last_word)
);

[bench/multiword_restoring_divider_tb.sv]
// self-checking bench for the multiword restoring divider: word-pair requests, quotient check
`timescale 1ns / 100ps

module multiword_restoring_divider_tb;

   localparam int RANDOM_DIVIDES = 8;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int PRINT_LIMIT    = 100;

   typedef struct {
      logic [mwd_pkg::WORD_W-1:0] dividend;
      logic [mwd_pkg::WORD_W-1:0] divisor;
      int                         gap;     // idle cycles before this request
      bit                         drain;   // hold off until every quotient word is back
   } word_pair_type;

   typedef struct {
      logic [mwd_pkg::WORD_W-1:0] quotient;
      logic                       last;
   } quotient_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic [mwd_pkg::WORD_W-1:0] req_dividend_word = '0;
   logic [mwd_pkg::WORD_W-1:0] req_divisor_word = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [mwd_pkg::WORD_W-1:0] rsp_quotient_word;
   logic                       rsp_last_word;

   word_pair_type               word_pairs[$];
   quotient_word_type           quotient_due[$];
   logic [mwd_pkg::TOTAL_W-1:0] dividend_acc = '0;
   logic [mwd_pkg::TOTAL_W-1:0] divisor_acc = '0;
   int                          load_pos = 0;
   bit                          req_taken = 1'b0;
   int                          idle_count = 0;
   int                          fail_count = 0;
   int                          cycle_count = 0;

   multiword_restoring_divider uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_dividend_word (req_dividend_word),
      .req_divisor_word  (req_divisor_word),
      .rsp_valid         (rsp_valid),
      .rsp_quotient_word (rsp_quotient_word),
      .rsp_last_word     (rsp_last_word)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shift-subtract with the bit that falls off the top kept as a carry;
   // a zero divisor makes every trial succeed, giving all ones
   function automatic logic [mwd_pkg::TOTAL_W-1:0] restoring_quotient(
      input logic [mwd_pkg::TOTAL_W-1:0] num,
      input logic [mwd_pkg::TOTAL_W-1:0] den);
      logic [mwd_pkg::TOTAL_W:0]   part;
      logic [mwd_pkg::TOTAL_W-1:0] quo;
      part = '0;
      quo = '0;
      for (int b = mwd_pkg::TOTAL_W - 1; b >= 0; b--) begin
         part = {part[mwd_pkg::TOTAL_W-1:0], num[b]};
         if (part[mwd_pkg::TOTAL_W] || part[mwd_pkg::TOTAL_W-1:0] >= den) begin
            part = {1'b0, part[mwd_pkg::TOTAL_W-1:0] - den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // random word weighted toward the corners
   function automatic logic [mwd_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return mwd_pkg::WORD_W'(1);
         3: return {1'b1, {(mwd_pkg::WORD_W-1){1'b0}}};
         default: return $urandom;
      endcase
   endfunction

   // split one divide into WORDS requests, least significant word first
   task automatic queue_divide(input logic [mwd_pkg::TOTAL_W-1:0] num,
                               input logic [mwd_pkg::TOTAL_W-1:0] den,
                               input bit drain);
      word_pair_type pair;
      bit            eager;
      eager = ($urandom_range(0, 2) == 0);
      for (int w = 0; w < mwd_pkg::WORDS; w++) begin
         pair.dividend = num[w*mwd_pkg::WORD_W +: mwd_pkg::WORD_W];
         pair.divisor  = den[w*mwd_pkg::WORD_W +: mwd_pkg::WORD_W];
         pair.gap      = eager ? 0 : $urandom_range(0, 4);
         pair.drain    = drain && (w == 0);
         word_pairs.push_back(pair);
      end
   endtask

   // request driver, changes inputs on the falling edge
   always @(negedge clock) begin
      word_pair_type next_pair;
      if (reset) begin
         start <= 1'b0;
         idle_count = 0;
      end else if (!start || req_taken) begin
         if (word_pairs.size() != 0 && idle_count >= word_pairs[0].gap &&
             (!word_pairs[0].drain || quotient_due.size() == 0)) begin
            next_pair = word_pairs.pop_front();
            req_dividend_word <= next_pair.dividend;
            req_divisor_word <= next_pair.divisor;
            start <= 1'b1;
            idle_count = 0;
         end else begin
            start <= 1'b0;
            if (word_pairs.size() != 0 && idle_count < word_pairs[0].gap)
               idle_count++;
         end
      end
   end

   // monitor: check quotient words, then fold accepted requests into the prediction
   always @(posedge clock) begin
      quotient_word_type           due;
      logic [mwd_pkg::TOTAL_W-1:0] quo;
      if (reset) begin
         req_taken = 1'b0;
         load_pos = 0;
      end else begin
         if (rsp_valid) begin
            if (quotient_due.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_LIMIT)
                  $display("%0t: unexpected quotient word, expected none, got %h last %b",
                           $time, rsp_quotient_word, rsp_last_word);
            end else begin
               due = quotient_due.pop_front();
               if (rsp_quotient_word !== due.quotient) begin
                  fail_count++;
                  if (fail_count <= PRINT_LIMIT)
                     $display("%0t: quotient word mismatch, expected %h, got %h",
                              $time, due.quotient, rsp_quotient_word);
               end
               if (rsp_last_word !== due.last) begin
                  fail_count++;
                  if (fail_count <= PRINT_LIMIT)
                     $display("%0t: last word flag mismatch, expected %b, got %b",
                              $time, due.last, rsp_last_word);
               end
            end
         end
         req_taken = start && !busy;
         if (req_taken) begin
            dividend_acc[load_pos*mwd_pkg::WORD_W +: mwd_pkg::WORD_W] = req_dividend_word;
            divisor_acc[load_pos*mwd_pkg::WORD_W +: mwd_pkg::WORD_W] = req_divisor_word;
            if (load_pos == mwd_pkg::WORDS - 1) begin
               quo = restoring_quotient(dividend_acc, divisor_acc);
               for (int w = 0; w < mwd_pkg::WORDS; w++) begin
                  due.quotient = quo[w*mwd_pkg::WORD_W +: mwd_pkg::WORD_W];
                  due.last = (w == mwd_pkg::WORDS - 1);
                  quotient_due.push_back(due);
               end
               load_pos = 0;
            end else begin
               load_pos++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      logic [mwd_pkg::TOTAL_W-1:0] num;
      logic [mwd_pkg::TOTAL_W-1:0] den;
      int                          num_len;
      int                          den_len;

      // corner divides: zero divisor, unit divisor, equal operands,
      // divisor with the top bit set (carry out of the partial remainder),
      // and a zero dividend
      queue_divide('1, '0, 1'b0);
      queue_divide('1, {{(mwd_pkg::TOTAL_W-1){1'b0}}, 1'b1}, 1'b1);
      queue_divide('1, '1, 1'b0);
      queue_divide('1, {1'b1, {(mwd_pkg::TOTAL_W-2){1'b0}}, 1'b1}, 1'b0);
      queue_divide('0, '1, 1'b1);

      // random divides, short divisors favored so quotients get wide
      for (int d = 0; d < RANDOM_DIVIDES; d++) begin
         num = '0;
         den = '0;
         num_len = $urandom_range(1, mwd_pkg::WORDS);
         if ($urandom_range(0, 7) == 0)
            den_len = 0;
         else if ($urandom_range(0, 1) == 0)
            den_len = $urandom_range(1, 4);
         else
            den_len = $urandom_range(1, mwd_pkg::WORDS);
         for (int w = 0; w < num_len; w++)
            num[w*mwd_pkg::WORD_W +: mwd_pkg::WORD_W] = pick_word();
         for (int w = 0; w < den_len; w++)
            den[w*mwd_pkg::WORD_W +: mwd_pkg::WORD_W] = pick_word();
         queue_divide(num, den, $urandom_range(0, 3) == 0);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (word_pairs.size() != 0 || start || quotient_due.size() != 0)
         @(posedge clock);
      repeat (2 * mwd_pkg::WORDS) @(posedge clock);

      if (fail_count == 0 && quotient_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
hdl/mwd_pkg.sv
hdl/mwd_datapath.sv
hdl/mwd_ctrl.sv
hdl/multiword_restoring_divider.sv
hdl/mwd_checker.sv
bench/multiword_restoring_divider_tb.sv
